// File: hw/rtl/bole_pkg.sv
// package: request and response types, operation codes and sequencer states
`default_nettype none

package bole_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT_AT     = 3'd0,
    KIND_INSERT_SORTED = 3'd1,
    KIND_ERASE_AT      = 3'd2,
    KIND_REMOVE_ALL    = 3'd3,
    KIND_GET           = 3'd4,
    KIND_SET           = 3'd5,
    KIND_FIND          = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_PLACE,
    ST_SHIFT_DN,
    ST_GET_RD,
    ST_GET_DATA,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  position;
    logic [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [6:0]  where;
    logic [31:0] read_value;
    logic [6:0]  removed_count;
    logic [6:0]  used_count;
  } rsp_t;

  // result of the shared compare unit
  typedef struct packed {
    logic eq;
    logic ge;
  } cmp_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/bole_stream_if.sv
// interface: valid/ready stream channel with a typed payload
`default_nettype none

interface bole_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/bole_mem.sv
// entry memory: one write port, one read port with registered read data
`default_nettype none

module bole_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/bole_cmp.sv
// shared compare unit: entry against the operand value
`default_nettype none

module bole_cmp
  import bole_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic [WIDTH-1:0] entry_i,
  input  wire logic [WIDTH-1:0] value_i,
  output cmp_res_t              res_o
);

  always_comb begin
    res_o.eq = (entry_i == value_i);
    res_o.ge = (entry_i >= value_i);
  end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_ordered_list_engine.sv
// top level: bounded ordered list engine with sequencer, entry memory and compare unit
`default_nettype none

// Keeps a list of up to CAPACITY entries of ITEM_WIDTH bits in a single memory with one
// write and one registered read port, plus a fill count. Each request carries one
// operation and gives exactly one response. A small sequencer walks the memory one entry
// per cycle, reading one entry while writing the previously read one, with a single
// compare unit judging each entry as it arrives. The block takes no new request while an
// operation runs; a finished response sits in an output register, so the next request
// is taken while it waits. Set writes the entry on accept; get reads it; insert_at
// shifts the entries from position upward and then writes the item; erase_at shifts the
// entries above position down; find and remove_all scan up to the whole list, and
// insert_sorted scans for the first entry not below the item, then shifts up and writes.
// Bad positions, a full list and the unused kind answer with ok low.
module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int ITEM_WIDTH = 32
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  bole_stream_if.sink   req_i,
  bole_stream_if.source rsp_o
);

  // counter width covers both the fill count and the 7-bit position field
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic [CW-1:0]         pos_q, pos_d;        // insert slot or operand position
  logic [ITEM_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [CW-1:0]         idx_q, idx_d;        // walk index
  logic [CW-1:0]         wj_q, wj_d;          // compaction write index
  logic [CW-1:0]         removed_q, removed_d;
  logic                  ok_q, ok_d;
  logic [CW-1:0]         where_q, where_d;
  logic [31:0]           rd_q, rd_d;
  logic                  rv_q, rv_d;          // read data arrives this cycle
  logic [CW-1:0]         rtag_q, rtag_d;      // index that the arriving data belongs to
  rsp_t                  rsp_q, rsp_d;
  logic                  rsp_valid_q, rsp_valid_d;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_rdata;
  cmp_res_t              cmp_res;

  logic [CW-1:0]         pos_in;
  logic [ITEM_WIDTH-1:0] val_in;
  logic [CW-1:0]         idx_inc;
  logic [CW-1:0]         idx_dec;
  logic                  stop;

  assign pos_in  = CW'(req_i.payload.position);
  assign val_in  = ITEM_WIDTH'(req_i.payload.item_value);
  assign idx_inc = idx_q + 1'b1;
  assign idx_dec = idx_q - 1'b1;

  bole_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ITEM_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // every scan decision goes through this one compare against the operand
  bole_cmp #(
    .WIDTH (ITEM_WIDTH)
  ) u_cmp (
    .entry_i (mem_rdata),
    .value_i (val_q),
    .res_o   (cmp_res)
  );

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    val_d       = val_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    wj_d        = wj_q;
    removed_d   = removed_q;
    ok_d        = ok_q;
    where_d     = where_q;
    rd_d        = rd_q;
    rv_d        = 1'b0;
    rtag_d      = rtag_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = rtag_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = idx_q[AW-1:0];
    stop        = 1'b0;
    req_i.ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          kind_d    = kind_e'(req_i.payload.kind);
          pos_d     = pos_in;
          val_d     = val_in;
          ok_d      = 1'b0;
          where_d   = '0;
          rd_d      = '0;
          removed_d = '0;
          wj_d      = '0;
          idx_d     = '0;
          state_d   = ST_FINISH;
          case (kind_e'(req_i.payload.kind))
            KIND_INSERT_AT: begin
              if (pos_in <= fill_q && fill_q < CAP_C) begin
                idx_d   = fill_q;
                state_d = ST_SHIFT_UP;
              end
            end
            KIND_INSERT_SORTED: begin
              if (fill_q < CAP_C) begin
                state_d = ST_SCAN;
              end
            end
            KIND_ERASE_AT: begin
              if (pos_in < fill_q) begin
                idx_d   = pos_in;
                state_d = ST_SHIFT_DN;
              end
            end
            KIND_REMOVE_ALL,
            KIND_FIND: begin
              state_d = ST_SCAN;
            end
            KIND_GET: begin
              if (pos_in < fill_q) begin
                state_d = ST_GET_RD;
              end
            end
            KIND_SET: begin
              if (pos_in < fill_q) begin
                mem_we    = 1'b1;
                mem_waddr = pos_in[AW-1:0];
                mem_wdata = val_in;
                ok_d      = 1'b1;
              end
            end
            default: begin
              // unused kind: nothing changes, ok stays low
            end
          endcase
        end
      end

      // ascending walk: read idx, judge the previously read entry
      ST_SCAN: begin
        if (rv_q) begin
          case (kind_q)
            KIND_INSERT_SORTED: begin
              if (cmp_res.ge) begin
                stop    = 1'b1;
                pos_d   = rtag_q;
                where_d = rtag_q;
                ok_d    = 1'b1;
                idx_d   = fill_q;
                state_d = ST_SHIFT_UP;
              end
            end
            KIND_FIND: begin
              if (cmp_res.eq) begin
                stop    = 1'b1;
                where_d = rtag_q;
                ok_d    = 1'b1;
                state_d = ST_FINISH;
              end
            end
            KIND_REMOVE_ALL: begin
              if (cmp_res.eq) begin
                removed_d = removed_q + 1'b1;
              end else begin
                // compaction write lands at or below the entry just read
                mem_we    = 1'b1;
                mem_waddr = wj_q[AW-1:0];
                wj_d      = wj_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        if (!stop) begin
          if (idx_q < fill_q) begin
            rv_d   = 1'b1;
            rtag_d = idx_q;
            idx_d  = idx_inc;
          end else if (!rv_q) begin
            // walked past the last entry
            case (kind_q)
              KIND_INSERT_SORTED: begin
                pos_d   = fill_q;
                where_d = fill_q;
                ok_d    = 1'b1;
                idx_d   = fill_q;
                state_d = ST_SHIFT_UP;
              end
              KIND_REMOVE_ALL: begin
                fill_d  = wj_q;
                ok_d    = 1'b1;
                state_d = ST_FINISH;
              end
              default: begin
                state_d = ST_FINISH;
              end
            endcase
          end
        end
      end

      // descending move: idx is the destination, its source is idx - 1
      ST_SHIFT_UP: begin
        if (rv_q) begin
          mem_we = 1'b1;
        end
        if (idx_q > pos_q) begin
          mem_raddr = idx_dec[AW-1:0];
          rv_d      = 1'b1;
          rtag_d    = idx_q;
          idx_d     = idx_dec;
        end else if (!rv_q) begin
          state_d = ST_PLACE;
        end
      end

      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = val_q;
        fill_d    = fill_q + 1'b1;
        ok_d      = 1'b1;
        state_d   = ST_FINISH;
      end

      // ascending move: idx is the destination, its source is idx + 1
      ST_SHIFT_DN: begin
        if (rv_q) begin
          mem_we = 1'b1;
        end
        if (idx_inc < fill_q) begin
          mem_raddr = idx_inc[AW-1:0];
          rv_d      = 1'b1;
          rtag_d    = idx_q;
          idx_d     = idx_inc;
        end else if (!rv_q) begin
          fill_d  = fill_q - 1'b1;
          ok_d    = 1'b1;
          state_d = ST_FINISH;
        end
      end

      ST_GET_RD: begin
        mem_raddr = pos_q[AW-1:0];
        state_d   = ST_GET_DATA;
      end

      ST_GET_DATA: begin
        rd_d    = 32'(mem_rdata);
        ok_d    = 1'b1;
        state_d = ST_FINISH;
      end

      // load the output register once it is free
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_d.ok            = ok_q;
          rsp_d.where         = where_q[6:0];
          rsp_d.read_value    = rd_q;
          rsp_d.removed_count = removed_q[6:0];
          rsp_d.used_count    = fill_q[6:0];
          rsp_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rv_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rv_q        <= rv_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // operand and result payload
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    wj_q      <= wj_d;
    removed_q <= removed_d;
    ok_q      <= ok_d;
    where_q   <= where_d;
    rd_q      <= rd_d;
    rtag_q    <= rtag_d;
    rsp_q     <= rsp_d;
  end

endmodule

`default_nettype wire
